### rtl/dcppv_pkg.sv
// Package for the dilated convolution feature core: field widths, fixed-point
// limits, opcodes, register indexes, sequencer states and the tap control beat.
// No dependencies.
package dcppv_pkg;

	localparam int IDX_W    = 10;
	localparam int SMP_W    = 16;
	localparam int BIAS_W   = 32;
	localparam int PROD_W   = 32;
	localparam int ACC_W    = 40;
	localparam int CNT_W    = 11;
	localparam int DIL_W    = 10;
	localparam int PAD_W    = 9;
	localparam int TAPCFG_W = 5;
	localparam int LEN_W    = 11;
	localparam int CFGIDX_W = 2;
	localparam int CFGDAT_W = 11;
	localparam int OP_W     = 2;

	localparam int IN_TDATA_W  = 64;
	localparam int OUT_TDATA_W = 56;

	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
	localparam logic [CNT_W-1:0]        CNT_MAX = '1;

	localparam logic [DIL_W-1:0]    DIL_RST = DIL_W'(1);
	localparam logic [PAD_W-1:0]    PAD_RST = '0;
	localparam logic [TAPCFG_W-1:0] TAP_RST = TAPCFG_W'(9);
	localparam logic [LEN_W-1:0]    LEN_RST = LEN_W'(1024);

	typedef enum logic [OP_W-1:0] {
		OP_WEIGHT = 2'd0,
		OP_BIAS   = 2'd1,
		OP_SAMPLE = 2'd2
	} op_t;

	typedef enum logic [CFGIDX_W-1:0] {
		CFG_DILATION = 2'd0,
		CFG_PADDING  = 2'd1,
		CFG_TAPS     = 2'd2,
		CFG_LENGTH   = 2'd3
	} cfg_reg_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SPAN,
		S_PREP,
		S_RUN,
		S_DRAIN,
		S_FLUSH
	} seq_state_t;

	typedef struct packed {
		logic issue;  // one tap multiply-accumulate
		logic inr;    // sample index inside the series
		logic first;  // first tap of a position
		logic last;   // last tap of a position
		logic fin;    // last beat of the whole run
	} tap_ctl_t;

endpackage

### rtl/dilated_conv_ppv_max_feature_core.sv
// Top level of the dilated convolution feature core: stream ports, config
// registers, bias register and output register. Depends on dcppv_pkg,
// dcppv_store, dcppv_seq and dcppv_mac.

// Load beats (weight, bias, sample) are stored as they are accepted. A sample beat with
// tlast starts a run over P = length + 2*padding - (taps-1)*dilation
// output positions, after which one beat leaves on m_axis with the count of
// positive sums and the largest sum. During a run the core issues one multiply-accumulate
// per tap per cycle through the single shared MAC, between setup and
// pipeline drain. s_axis_tready is low during a run and until its result has
// entered the output register.
module dilated_conv_ppv_max_feature_core
	import dcppv_pkg::*;
#(
	parameter int MAX_SERIES = 1024,
	parameter int MAX_TAPS   = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFGIDX_W-1:0]    cfg_index,
	input  logic [CFGDAT_W-1:0]    cfg_data,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // index[9:0], value[25:10], bias_value[57:26]
	input  logic                   s_axis_tlast,  // last_sample
	input  logic [OP_W-1:0]        s_axis_tuser,  // op[1:0]
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata   // positive_count[10:0], max_response[50:11]
);

	localparam int AW = $clog2(MAX_SERIES);
	localparam int TW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;

	logic [DIL_W-1:0]    dil_q;
	logic [PAD_W-1:0]    pad_q;
	logic [TAPCFG_W-1:0] taps_q;
	logic [LEN_W-1:0]    len_q;
	logic signed [BIAS_W-1:0] bias_q;

	logic [IDX_W-1:0]          in_index;
	logic signed [SMP_W-1:0]   in_value;
	logic signed [BIAS_W-1:0]  in_bias;
	op_t                       in_op;
	logic                      in_acc;
	logic                      w_we, x_we, start;

	logic                      idle, clear, emit, done, out_free;
	tap_ctl_t                  ctl;
	logic [AW-1:0]             x_raddr;
	logic [TW-1:0]             w_raddr;
	logic signed [SMP_W-1:0]   w_rdata, x_rdata;
	logic [CNT_W-1:0]          count;
	logic signed [ACC_W-1:0]   max_resp;

	logic                      out_vld_q;
	logic [OUT_TDATA_W-1:0]    out_data_q;

	assign in_index = s_axis_tdata[IDX_W-1:0];
	assign in_value = s_axis_tdata[IDX_W+SMP_W-1:IDX_W];
	assign in_bias  = s_axis_tdata[IDX_W+SMP_W+BIAS_W-1:IDX_W+SMP_W];
	assign in_op    = op_t'(s_axis_tuser);

	assign s_axis_tready = idle;
	assign in_acc = s_axis_tvalid && s_axis_tready;
	assign w_we   = in_acc && (in_op == OP_WEIGHT) && (32'(in_index) < 32'(MAX_TAPS));
	assign x_we   = in_acc && (in_op == OP_SAMPLE) && (32'(in_index) < 32'(MAX_SERIES));
	assign start  = in_acc && (in_op == OP_SAMPLE) && s_axis_tlast;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dil_q  <= DIL_RST;
			pad_q  <= PAD_RST;
			taps_q <= TAP_RST;
			len_q  <= LEN_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_DILATION: dil_q  <= cfg_data[DIL_W-1:0];
				CFG_PADDING:  pad_q  <= cfg_data[PAD_W-1:0];
				CFG_TAPS:     taps_q <= cfg_data[TAPCFG_W-1:0];
				CFG_LENGTH:   len_q  <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bias_q <= '0;
		end else if (in_acc && (in_op == OP_BIAS)) begin
			bias_q <= in_bias;
		end
	end

	dcppv_store #(
		.MAX_SERIES (MAX_SERIES),
		.MAX_TAPS   (MAX_TAPS)
	) u_store (
		.clk     (clk),
		.w_we    (w_we),
		.w_waddr (TW'(in_index)),
		.x_we    (x_we),
		.x_waddr (AW'(in_index)),
		.wdata   (in_value),
		.w_raddr (w_raddr),
		.x_raddr (x_raddr),
		.w_rdata (w_rdata),
		.x_rdata (x_rdata)
	);

	dcppv_seq #(
		.MAX_SERIES (MAX_SERIES),
		.MAX_TAPS   (MAX_TAPS)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.dilation   (dil_q),
		.padding    (pad_q),
		.tap_count  (taps_q),
		.series_len (len_q),
		.done       (done),
		.out_free   (out_free),
		.idle       (idle),
		.clear      (clear),
		.emit       (emit),
		.ctl        (ctl),
		.x_raddr    (x_raddr),
		.w_raddr    (w_raddr)
	);

	dcppv_mac u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.clear    (clear),
		.ctl      (ctl),
		.w_rdata  (w_rdata),
		.x_rdata  (x_rdata),
		.bias     (bias_q),
		.done     (done),
		.count    (count),
		.max_resp (max_resp)
	);

	assign out_free = !out_vld_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (emit) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_data_q <= OUT_TDATA_W'({max_resp, count});
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_data_q;

endmodule

### rtl/dcppv_store.sv
// Weight and series sample memories, one write port and one registered read
// port each. Depends on dcppv_pkg.
module dcppv_store
	import dcppv_pkg::*;
#(
	parameter int MAX_SERIES = 1024,
	parameter int MAX_TAPS   = 16,
	localparam int AW = $clog2(MAX_SERIES),
	localparam int TW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1
) (
	input  logic                    clk,
	input  logic                    w_we,
	input  logic [TW-1:0]           w_waddr,
	input  logic                    x_we,
	input  logic [AW-1:0]           x_waddr,
	input  logic signed [SMP_W-1:0] wdata,
	input  logic [TW-1:0]           w_raddr,
	input  logic [AW-1:0]           x_raddr,
	output logic signed [SMP_W-1:0] w_rdata,
	output logic signed [SMP_W-1:0] x_rdata
);

	logic signed [SMP_W-1:0] w_mem [MAX_TAPS];
	logic signed [SMP_W-1:0] x_mem [MAX_SERIES];

	always_ff @(posedge clk) begin
		if (w_we) begin
			w_mem[w_waddr] <= wdata;
		end
		w_rdata <= w_mem[w_raddr];
	end

	always_ff @(posedge clk) begin
		if (x_we) begin
			x_mem[x_waddr] <= wdata;
		end
		x_rdata <= x_mem[x_raddr];
	end

endmodule

### rtl/dcppv_seq.sv
// Sequencer: walks output positions and taps, generates memory addresses and
// the tap control beat, and runs the result handoff. Depends on dcppv_pkg.
module dcppv_seq
	import dcppv_pkg::*;
#(
	parameter int MAX_SERIES = 1024,
	parameter int MAX_TAPS   = 16,
	localparam int AW = $clog2(MAX_SERIES),
	localparam int TW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [DIL_W-1:0]    dilation,
	input  logic [PAD_W-1:0]    padding,
	input  logic [TAPCFG_W-1:0] tap_count,
	input  logic [LEN_W-1:0]    series_len,
	input  logic                done,
	input  logic                out_free,
	output logic                idle,
	output logic                clear,
	output logic                emit,
	output tap_ctl_t            ctl,
	output logic [AW-1:0]       x_raddr,
	output logic [TW-1:0]       w_raddr
);

	localparam int TCW = $clog2(MAX_TAPS + 1);
	localparam int LW  = $clog2(MAX_SERIES + 1);
	localparam int SPW = TCW + DIL_W;
	localparam int PSW = ((LW > SPW) ? LW : SPW) + 2;
	localparam int RW  = PSW - 1;
	localparam int SW  = ((LW > PAD_W + 1) ? LW : PAD_W + 1) + 2;

	seq_state_t state_q, state_d;

	logic [SPW-1:0]       span_q;
	logic [RW-1:0]        rem_q;
	logic signed [SW-1:0] s0_q;
	logic signed [SW-1:0] s_q;
	logic [TCW-1:0]       i_q;

	logic [TCW-1:0]        taps_c;
	logic [LW-1:0]         len_c;
	logic signed [PSW-1:0] pos_c;
	logic                  pos_ok;
	logic                  last_tap;
	logic                  in_rng;
	logic                  run_end;

	always_comb begin
		taps_c = (32'(tap_count) > 32'(MAX_TAPS)) ? TCW'(MAX_TAPS) : TCW'(tap_count);
		len_c  = (32'(series_len) > 32'(MAX_SERIES)) ? LW'(MAX_SERIES)
		                                              : LW'(series_len);
		pos_c  = $signed(PSW'(len_c) + PSW'({padding, 1'b0}) - PSW'(span_q));
		pos_ok = !pos_c[PSW-1] && (pos_c != '0);
		last_tap = (taps_c == '0) || (i_q == taps_c - TCW'(1));
		in_rng   = !s_q[SW-1] && (s_q < $signed(SW'(len_c))) && (taps_c != '0);
		run_end  = last_tap && (rem_q == '0);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:  if (start) state_d = S_SPAN;
			S_SPAN:  state_d = S_PREP;
			S_PREP:  state_d = pos_ok ? S_RUN : S_DRAIN;
			S_RUN:   if (run_end) state_d = S_DRAIN;
			S_DRAIN: if (done) state_d = S_FLUSH;
			S_FLUSH: if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		idle  = 1'b0;
		clear = 1'b0;
		emit  = 1'b0;
		ctl   = '0;
		unique case (state_q)
			S_IDLE:  idle = 1'b1;
			S_SPAN:  clear = 1'b1;
			S_PREP:  ctl.fin = !pos_ok;
			S_RUN: begin
				ctl.issue = 1'b1;
				ctl.inr   = in_rng;
				ctl.first = (i_q == '0);
				ctl.last  = last_tap;
				ctl.fin   = run_end;
			end
			S_DRAIN: ;
			S_FLUSH: emit = out_free;
			default: ;
		endcase
	end

	assign x_raddr = s_q[AW-1:0];
	assign w_raddr = i_q[TW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_SPAN: begin
				span_q <= (taps_c == '0) ? '0
				        : SPW'(SPW'(taps_c - TCW'(1)) * SPW'(dilation));
			end
			S_PREP: begin
				rem_q <= RW'(pos_c - PSW'(1));
				s0_q  <= SW'(0) - $signed(SW'(padding));
				s_q   <= SW'(0) - $signed(SW'(padding));
				i_q   <= '0;
			end
			S_RUN: begin
				if (last_tap) begin
					if (rem_q != '0) begin
						rem_q <= rem_q - RW'(1);
						s0_q  <= s0_q + SW'(1);
						s_q   <= s0_q + SW'(1);
						i_q   <= '0;
					end
				end else begin
					i_q <= i_q + TCW'(1);
					s_q <= s_q + $signed(SW'(dilation));
				end
			end
			default: ;
		endcase
	end

endmodule

### rtl/dcppv_mac.sv
// Shared multiply-accumulate unit with 40-bit saturation, followed by the
// positive-count and running-max stage. Depends on dcppv_pkg.
module dcppv_mac
	import dcppv_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     clear,
	input  tap_ctl_t                 ctl,
	input  logic signed [SMP_W-1:0]  w_rdata,
	input  logic signed [SMP_W-1:0]  x_rdata,
	input  logic signed [BIAS_W-1:0] bias,
	output logic                     done,
	output logic [CNT_W-1:0]         count,
	output logic signed [ACC_W-1:0]  max_resp
);

	tap_ctl_t ctl_s1, ctl_s2, ctl_s3;

	logic signed [PROD_W-1:0] prod_c;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]  acc_s3;
	logic signed [ACC_W-1:0]  base_c;
	logic signed [ACC_W:0]    sum_c;
	logic signed [ACC_W-1:0]  sat_c;
	logic [CNT_W-1:0]         count_q;
	logic signed [ACC_W-1:0]  max_q;
	logic                     done_q;

	always_comb begin
		prod_c = w_rdata * x_rdata;
		base_c = ctl_s2.first ? ACC_W'(bias) : acc_s3;
		sum_c  = (ACC_W + 1)'(base_c) + (ACC_W + 1)'(prod_s2);
		if (sum_c[ACC_W] != sum_c[ACC_W-1]) begin
			sat_c = sum_c[ACC_W] ? ACC_MIN : ACC_MAX;
		end else begin
			sat_c = sum_c[ACC_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			done_q <= 1'b0;
		end else begin
			ctl_s1 <= ctl;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			done_q <= ctl_s3.fin;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= ctl_s1.inr ? prod_c : '0;
		if (ctl_s2.issue) begin
			acc_s3 <= sat_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			max_q   <= ACC_MIN;
		end else if (clear) begin
			count_q <= '0;
			max_q   <= ACC_MIN;
		end else if (ctl_s3.issue && ctl_s3.last) begin
			if (!acc_s3[ACC_W-1] && (acc_s3 != '0) && (count_q != CNT_MAX)) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (acc_s3 > max_q) begin
				max_q <= acc_s3;
			end
		end
	end

	assign done     = done_q;
	assign count    = count_q;
	assign max_resp = max_q;

endmodule

### rtl/dcppv_checker.sv
// Port-level checks for the dilated convolution feature core, bound to the
// top level. Depends on dcppv_pkg.
module dcppv_checker
	import dcppv_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_axis_tvalid,
	input logic                   s_axis_tready,
	input logic                   s_axis_tlast,
	input logic [OP_W-1:0]        s_axis_tuser,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	logic [CNT_W-1:0]        chk_count;
	logic signed [ACC_W-1:0] chk_max;

	assign chk_count = m_axis_tdata[CNT_W-1:0];
	assign chk_max   = m_axis_tdata[CNT_W+ACC_W-1:CNT_W];

	// a run-starting beat blocks the input
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tlast && (s_axis_tuser == OP_SAMPLE)
		|=> !s_axis_tready)
		else $error("input ready right after a run start");

	// results only come out of a run
	a_result_from_run: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> !$past(s_axis_tready))
		else $error("result beat without a run");

	// any positive sum makes the max positive, and the reverse
	a_count_vs_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ((chk_count != '0) == (chk_max > 0)))
		else $error("positive count disagrees with max response");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output beat dropped or changed while stalled");

endmodule

bind dilated_conv_ppv_max_feature_core dcppv_checker u_dcppv_checker (.*);
